@@ rtl/core/apu_nch_pkg.sv @@
// Package with the request and response types and the constants of the noise channel.
package apu_nch_pkg;

	typedef enum logic [2:0] {
		OP_WRITE  = 3'd0,
		OP_READ   = 3'd1,
		OP_FREQ   = 3'd2,
		OP_LENGTH = 3'd3,
		OP_ENV    = 3'd4
	} op_t;

	localparam logic [1:0] REG_LENGTH  = 2'd0;
	localparam logic [1:0] REG_ENVELOPE = 2'd1;
	localparam logic [1:0] REG_FREQ    = 2'd2;
	localparam logic [1:0] REG_CONTROL = 2'd3;

	localparam int PERIOD_W = 20;
	localparam int LENGTH_W = 7;
	localparam logic [LENGTH_W-1:0] LENGTH_FULL = 7'd64;
	localparam logic [3:0] SHIFT_LIMIT = 4'd14;
	localparam logic [3:0] VOLUME_MAX = 4'd15;

	typedef struct packed {
		logic [2:0] op;
		logic [1:0] reg_index;
		logic [7:0] write_data;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [3:0] sample;
		logic       channel_on;
	} rsp_t;

	typedef struct packed {
		logic valid;
		req_t req;
	} stage_t;

	function automatic logic [PERIOD_W-1:0] divider_reload(input logic [7:0] freq_reg);
		logic [6:0] base;
		logic [PERIOD_W+14:0] wide;
		base = (freq_reg[2:0] == 3'd0) ? 7'd8 : {freq_reg[2:0], 4'b0000};
		wide = {{(PERIOD_W + 8){1'b0}}, base} << freq_reg[7:4];
		return wide[PERIOD_W-1:0];
	endfunction

endpackage

@@ rtl/core/apu_noise_channel_unit.sv @@
// Top level of the noise sound channel: input register, event core and response register.
// A request is held in the input register, its response then in the response register.
// Throughput: one request per cycle while rsp_stall is low; the event update is combinational.
// Reset: arst_n clears the register file, all channel state and both valid flags.
// The channel comes out of reset powered off with a zero shift register and volume.
module apu_noise_channel_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  apu_nch_pkg::req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output apu_nch_pkg::rsp_t rsp
);
	import apu_nch_pkg::*;

	stage_t stage;
	rsp_t rsp_next;
	logic fire;

	apu_nch_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.fire      (fire),
		.req_stall (req_stall),
		.stage     (stage)
	);

	apu_nch_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.stage_req (stage.req),
		.fire      (fire),
		.rsp_next  (rsp_next)
	);

	apu_nch_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stage.valid),
		.rsp_next  (rsp_next),
		.rsp_stall (rsp_stall),
		.fire      (fire),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);
endmodule

@@ rtl/core/apu_nch_in_stage.sv @@
// Input register stage that holds one request until the core takes it.
module apu_nch_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  apu_nch_pkg::req_t req,
	input  logic              fire,
	output logic              req_stall,
	output apu_nch_pkg::stage_t stage
);
	import apu_nch_pkg::*;

	logic valid_s1;
	req_t req_s1;
	logic take;

	assign req_stall = valid_s1 && !fire;
	assign take = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= req;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.req = req_s1;
endmodule

@@ rtl/core/apu_nch_core.sv @@
// Channel state and the combinational event update that also forms the response.
module apu_nch_core (
	input  logic                clk,
	input  logic                arst_n,
	input  apu_nch_pkg::req_t   stage_req,
	input  logic                fire,
	output apu_nch_pkg::rsp_t   rsp_next
);
	import apu_nch_pkg::*;

	logic [7:0] reg_file_q [4];
	logic [LENGTH_W-1:0] length_q;
	logic [3:0] volume_q;
	logic [2:0] env_q;
	logic [PERIOD_W-1:0] period_q;
	logic [15:0] shift_q;
	logic powered_q;

	logic [7:0] reg_d [4];
	logic [LENGTH_W-1:0] length_d;
	logic [3:0] volume_d;
	logic [2:0] env_d;
	logic [PERIOD_W-1:0] period_d;
	logic [PERIOD_W-1:0] period_dec;
	logic [15:0] shift_d;
	logic [15:0] shift_fb;
	logic powered_d;
	logic fb;
	logic [7:0] rd;
	req_t rq;

	assign rq = stage_req;
	assign period_dec = period_q - {{(PERIOD_W-1){1'b0}}, 1'b1};
	assign fb = ~(shift_q[0] ^ shift_q[1]);

	always_comb begin
		shift_fb = {fb, shift_q[14:0]};
		if (reg_file_q[REG_FREQ][3]) begin
			shift_fb[7] = fb;
		end
	end

	always_comb begin
		reg_d = reg_file_q;
		length_d = length_q;
		volume_d = volume_q;
		env_d = env_q;
		period_d = period_q;
		shift_d = shift_q;
		powered_d = powered_q;
		rd = 8'd0;
		case (rq.op)
			OP_WRITE: begin
				reg_d[rq.reg_index] = rq.write_data;
				if (rq.reg_index == REG_LENGTH) begin
					length_d = LENGTH_FULL - {1'b0, rq.write_data[5:0]};
				end else if (rq.reg_index == REG_CONTROL && rq.write_data[7]) begin
					powered_d = 1'b1;
					period_d = divider_reload(reg_file_q[REG_FREQ]);
					volume_d = reg_file_q[REG_ENVELOPE][7:4];
					if (length_q == '0) begin
						length_d = LENGTH_FULL - {1'b0, reg_file_q[REG_LENGTH][5:0]};
					end
					env_d = reg_file_q[REG_ENVELOPE][2:0];
					shift_d = '0;
				end
			end
			OP_READ: begin
				rd = reg_file_q[rq.reg_index];
			end
			OP_FREQ: begin
				if (reg_file_q[REG_ENVELOPE][7:3] == 5'd0) begin
					powered_d = 1'b0;
				end
				if (reg_file_q[REG_FREQ][7:4] < SHIFT_LIMIT && powered_d) begin
					if (period_dec != '0) begin
						period_d = period_dec;
					end else begin
						period_d = divider_reload(reg_file_q[REG_FREQ]);
						shift_d = {1'b0, shift_fb[15:1]};
					end
				end
			end
			OP_LENGTH: begin
				if (reg_file_q[REG_CONTROL][6] && length_q != '0) begin
					length_d = length_q - {{(LENGTH_W-1){1'b0}}, 1'b1};
					if (length_d == '0) begin
						powered_d = 1'b0;
					end
				end
			end
			OP_ENV: begin
				if (reg_file_q[REG_ENVELOPE][2:0] != 3'd0) begin
					env_d = env_q - 3'd1;
					if (env_d == 3'd0) begin
						env_d = reg_file_q[REG_ENVELOPE][2:0];
						if (reg_file_q[REG_ENVELOPE][3]) begin
							if (volume_q < VOLUME_MAX) begin
								volume_d = volume_q + 4'd1;
							end
						end else if (volume_q != 4'd0) begin
							volume_d = volume_q - 4'd1;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				reg_file_q[i] <= 8'd0;
			end
			length_q <= '0;
			volume_q <= '0;
			env_q <= '0;
			period_q <= '0;
			shift_q <= '0;
			powered_q <= 1'b0;
		end else if (fire) begin
			reg_file_q <= reg_d;
			length_q <= length_d;
			volume_q <= volume_d;
			env_q <= env_d;
			period_q <= period_d;
			shift_q <= shift_d;
			powered_q <= powered_d;
		end
	end

	assign rsp_next.read_data = rd;
	assign rsp_next.sample = shift_d[0] ? volume_d : 4'd0;
	assign rsp_next.channel_on = powered_d;
endmodule

@@ rtl/core/apu_nch_out_reg.sv @@
// Response register that holds a finished response until the consumer takes it.
module apu_nch_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  apu_nch_pkg::rsp_t rsp_next,
	input  logic              rsp_stall,
	output logic              fire,
	output logic              rsp_valid,
	output apu_nch_pkg::rsp_t rsp
);
	import apu_nch_pkg::*;

	logic valid_q;
	rsp_t rsp_q;

	assign fire = in_valid && (!valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fire) begin
			valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = valid_q;
	assign rsp = rsp_q;
endmodule

@@ rtl/core/apu_nch_checker.sv @@
// Port-level checker for the noise channel and its bind to the top level.
module apu_nch_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input apu_nch_pkg::req_t req,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input apu_nch_pkg::rsp_t rsp
);
	import apu_nch_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("Stalled response changed or dropped.");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("Request stalled while the response side could take data.");

	a_stall_keeps_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |=> rsp_valid)
		else $error("Response vanished while requests were held back.");
endmodule

bind apu_noise_channel_unit apu_nch_checker u_apu_nch_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
